/* rtl/scheduled_pid_with_ramp_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scheduled PID block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_PID_WITH_RAMP_MACROS_SVH
`define SCHEDULED_PID_WITH_RAMP_MACROS_SVH
`ifndef SYNTHESIS
`define SPWR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SPWR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SPWR_ASSERT_SAME(lbl, ante, cons, msg)
`define SPWR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/spwr_pkg.sv */
// ----------------------------------------------------------------------------
// spwr_pkg
// Types and codes shared by the scheduled PID controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package spwr_pkg;

	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_SETPT  = 2'd1;
	localparam logic [1:0] MODE_RESET  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_MAX  = 2'd1;
	localparam logic [1:0] CLAMP_MIN  = 2'd2;
	localparam logic [1:0] CLAMP_LEM  = 2'd3;

	localparam logic [16:0] ONE_Q15 = 17'd32768;
	localparam logic [31:0] OUT_LIMITS_RST = 32'h7FFF_8000;

	typedef enum logic [2:0] {
		REG_P_GAINS, REG_I_GAINS, REG_D_GAINS, REG_OUT_LIMITS,
		REG_LOW_ERR_MIN, REG_RAMP, REG_IN_LIMITS, REG_DEADBAND
	} spwr_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_GAIN, ST_DIV_HI, ST_WAIT_HI, ST_DIV_LO, ST_WAIT_LO,
		ST_SUM, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_ACC, ST_RAMP, ST_CLAMP
	} spwr_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_ERR, OP_GAIN, OP_DIV_HI, OP_DIV_LO, OP_SUM,
		OP_MUL_P, OP_MUL_I, OP_MUL_D, OP_ACC, OP_RAMP, OP_CLAMP
	} spwr_op_t;

	typedef struct packed {
		logic     accept;
		spwr_op_t op;
	} spwr_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} spwr_status_t;

	typedef struct packed {
		logic [47:0] p_gains;
		logic [47:0] i_gains;
		logic [47:0] d_gains;
		logic [31:0] output_limits;
		logic [14:0] low_error_min;
		logic [30:0] ramp_settings;
		logic [31:0] input_limits;
		logic [15:0] deadband;
	} spwr_cfg_t;

endpackage
`default_nettype wire

/* rtl/spwr_ifs.sv */
// ----------------------------------------------------------------------------
// spwr channel interfaces
// Sample input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface spwr_in_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   mode;
	logic signed [DATA_WIDTH-1:0] measurement;
	logic signed [DATA_WIDTH-1:0] target;
	logic                         restart;
	modport source (output valid, mode, measurement, target, restart, input ready);
	modport sink (input valid, mode, measurement, target, restart, output ready);
endinterface

interface spwr_out_if #(parameter int DATA_WIDTH = 16);
	logic                       valid;
	logic                       ready;
	logic signed [15:0]         drive;
	logic signed [DATA_WIDTH:0] error_now;
	logic                       settled;
	logic                       ramp_limited;
	logic [1:0]                 clamp_kind;
	modport source (output valid, drive, error_now, settled, ramp_limited, clamp_kind,
		input ready);
	modport sink (input valid, drive, error_now, settled, ramp_limited, clamp_kind,
		output ready);
endinterface
`default_nettype wire

/* rtl/spwr_div.sv */
// ----------------------------------------------------------------------------
// spwr_div
// Restoring divider, one quotient bit per cycle: (dividend << GF) / divisor,
// truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module spwr_div #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic signed [15:0]              dividend,
	input  wire logic [15:0]                     divisor,
	output logic                                 done,
	output logic signed [16+GAIN_FRAC_BITS:0]    quot
);
	localparam int NW = 16 + GAIN_FRAC_BITS;
	localparam int CNW = $clog2(NW + 1);

	logic [NW-1:0]  work_q;
	logic [15:0]    rem_q;
	logic [15:0]    dvs_q;
	logic           neg_q;
	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [15:0]    mag;
	logic [16:0]    shifted;
	logic           ge;

	assign mag = dividend[15] ? 16'(-dividend) : 16'(dividend);
	assign shifted = {rem_q, work_q[NW-1]};
	assign ge = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= NW'(mag) << GAIN_FRAC_BITS;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[15];
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract where it fits
			rem_q <= ge ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
			work_q <= {work_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, work_q}) : $signed({1'b0, work_q});
endmodule
`default_nettype wire

/* rtl/spwr_ctrl.sv */
// ----------------------------------------------------------------------------
// spwr_ctrl
// Sequencer for one sample word: error, gains, two bound divisions, integral,
// three shared multiplies, ramp, clamp.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scheduled_pid_with_ramp_macros.svh"
module spwr_ctrl
	import spwr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [1:0]   in_mode,
	output logic              in_ready,
	input  wire spwr_status_t status,
	output spwr_cmd_t         cmd
);
	spwr_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_mode == MODE_SAMPLE) state_n = ST_ERR;
			end
			ST_ERR:     state_n = ST_GAIN;
			ST_GAIN:    state_n = ST_DIV_HI;
			ST_DIV_HI:  state_n = ST_WAIT_HI;
			ST_WAIT_HI: begin
				if (status.div_done) state_n = ST_DIV_LO;
			end
			ST_DIV_LO:  state_n = ST_WAIT_LO;
			ST_WAIT_LO: begin
				if (status.div_done) state_n = ST_SUM;
			end
			ST_SUM:     state_n = ST_MUL_P;
			ST_MUL_P:   state_n = ST_MUL_I;
			ST_MUL_I:   state_n = ST_MUL_D;
			ST_MUL_D:   state_n = ST_ACC;
			ST_ACC:     state_n = ST_RAMP;
			ST_RAMP:    state_n = ST_CLAMP;
			ST_CLAMP: begin
				if (status.out_free) state_n = ST_IDLE;
			end
			default:    state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.op = OP_NONE;
		case (state_q)
			ST_ERR:    cmd.op = OP_ERR;
			ST_GAIN:   cmd.op = OP_GAIN;
			ST_DIV_HI: cmd.op = OP_DIV_HI;
			ST_DIV_LO: cmd.op = OP_DIV_LO;
			ST_SUM:    cmd.op = OP_SUM;
			ST_MUL_P:  cmd.op = OP_MUL_P;
			ST_MUL_I:  cmd.op = OP_MUL_I;
			ST_MUL_D:  cmd.op = OP_MUL_D;
			ST_ACC:    cmd.op = OP_ACC;
			ST_RAMP:   cmd.op = OP_RAMP;
			ST_CLAMP:  cmd.op = status.out_free ? OP_CLAMP : OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

	`SPWR_ASSERT_NEXT(a_nonsample_idle, cmd.accept && in_mode != MODE_SAMPLE,
		state_q == ST_IDLE, "non-sample word left idle")
	`SPWR_ASSERT_NEXT(a_hi_to_lo, state_q == ST_WAIT_HI && status.div_done,
		state_q == ST_DIV_LO, "upper bound division not followed by lower")
	`SPWR_ASSERT_NEXT(a_clamp_hold, state_q == ST_CLAMP && !status.out_free,
		state_q == ST_CLAMP, "result dropped while output stalled")
endmodule
`default_nettype wire

/* rtl/spwr_dp.sv */
// ----------------------------------------------------------------------------
// spwr_dp
// PID datapath: state registers, gain pick, integral bounds, shared
// multiplier with accumulator, ramp limiter and output clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module spwr_dp
	import spwr_pkg::*;
#(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8,
	parameter int SUM_WIDTH      = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire spwr_cfg_t                    cfg,
	input  wire spwr_cmd_t                    cmd,
	output spwr_status_t                      status,
	input  wire logic [1:0]                   in_mode,
	input  wire logic signed [DATA_WIDTH-1:0] in_measurement,
	input  wire logic signed [DATA_WIDTH-1:0] in_target,
	input  wire logic                         in_restart,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [15:0]                out_drive,
	output logic signed [DATA_WIDTH:0]        out_error_now,
	output logic                              out_settled,
	output logic                              out_ramp_limited,
	output logic [1:0]                        out_clamp_kind
);
	localparam int TW  = (DATA_WIDTH > 16) ? DATA_WIDTH : 16;
	localparam int EW  = TW + 1;
	localparam int DFW = EW + 1;
	localparam int SC  = (SUM_WIDTH < GAIN_FRAC_BITS + 17) ? SUM_WIDTH : GAIN_FRAC_BITS + 17;
	localparam int BW  = (DFW > SC) ? DFW : SC;
	localparam int PW  = BW + 17;
	localparam int AW  = PW + 2;
	localparam int DRW = AW - GAIN_FRAC_BITS;
	localparam int QW  = 17 + GAIN_FRAC_BITS;
	localparam int CW  = (SUM_WIDTH + 2 > QW + 1) ? SUM_WIDTH + 2 : QW + 1;

	// persistent state
	logic signed [TW-1:0]        target_q;
	logic signed [EW-1:0]        last_err_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic [16:0]                 level_q;
	logic                        ramp_on_q;
	logic                        sign_pos_q;
	logic                        out_valid_q;

	// per-sample work registers
	logic signed [DATA_WIDTH-1:0] meas_q;
	logic signed [EW-1:0]         err_q;
	logic signed [DFW-1:0]        diff_q;
	logic [EW-1:0]                emag_q;
	logic [15:0]                  kp_q, ki_q, kd_q;
	logic                         settled_q;
	logic signed [QW-1:0]         hi_q;
	logic signed [PW-1:0]         prod_q;
	logic signed [AW-1:0]         acc_q;
	logic signed [DRW-1:0]        drive_q;
	logic                         ramped_q;
	logic signed [15:0]           drive_out_q;
	logic signed [DATA_WIDTH:0]   err_out_q;
	logic                         settled_out_q, ramped_out_q;
	logic [1:0]                   kind_out_q;

	logic                  div_start;
	logic signed [15:0]    div_dividend;
	logic                  div_done;
	logic signed [QW-1:0]  div_quot;

	function automatic logic [15:0] pick(input logic [47:0] r, input logic [EW-1:0] m);
		logic [15:0] g;
		g = r[31:16];
		if (r[47:32] != 16'd0 && m < EW'(r[47:32])) g = r[15:0];
		return g;
	endfunction

	assign div_start = (cmd.op == OP_DIV_HI) || (cmd.op == OP_DIV_LO);
	assign div_dividend = (cmd.op == OP_DIV_HI) ? $signed(cfg.output_limits[31:16])
		: $signed(cfg.output_limits[15:0]);

	spwr_div #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (ki_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	// setpoint clamp
	logic signed [TW-1:0] tgt_w, imax, imin, tgt_c;
	logic signed [EW-1:0] sp_err;
	always_comb begin
		tgt_w = TW'(in_target);
		imax = TW'($signed(cfg.input_limits[31:16]));
		imin = TW'($signed(cfg.input_limits[15:0]));
		tgt_c = tgt_w;
		if (imax > imin) begin
			if (tgt_w > imax) tgt_c = imax;
			else if (tgt_w < imin) tgt_c = imin;
		end
		sp_err = EW'(tgt_c) - EW'(in_measurement);
	end

	// error
	logic signed [EW-1:0] err_n;
	assign err_n = EW'(target_q) - EW'(meas_q);

	// integral update with division bounds
	logic signed [CW-1:0] s_raw, s_c, hi_c, lo_c, smax, smin;
	always_comb begin
		smax = CW'($signed({1'b0, {(SUM_WIDTH-1){1'b1}}}));
		smin = ~smax;
		hi_c = CW'(hi_q);
		lo_c = CW'(div_quot);
		s_raw = CW'(sum_q) + CW'(err_q);
		s_c = s_raw;
		if (s_c > hi_c) s_c = hi_c;
		if (s_c < lo_c) s_c = lo_c;
		if (s_c > smax) s_c = smax;
		if (s_c < smin) s_c = smin;
	end

	// shared multiplier
	logic signed [16:0]   mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	always_comb begin
		case (cmd.op)
			OP_MUL_I: begin
				mul_a = $signed({1'b0, ki_q});
				mul_b = BW'(sum_q);
			end
			OP_MUL_D: begin
				mul_a = $signed({1'b0, kd_q});
				mul_b = BW'(diff_q);
			end
			default: begin
				mul_a = $signed({1'b0, kp_q});
				mul_b = BW'(err_q);
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// ramp limiter
	logic signed [DRW-1:0] raw, lvl_s, ramp_drive;
	logic [17:0]           lvl_sum;
	logic [16:0]           lvl;
	logic                  ramp_on_n;
	always_comb begin
		raw = DRW'(acc_q >>> GAIN_FRAC_BITS);
		lvl_sum = 18'(level_q) + 18'(cfg.ramp_settings[15:0]);
		lvl = (lvl_sum > 18'(ONE_Q15)) ? ONE_Q15 : lvl_sum[16:0];
		lvl_s = DRW'($signed({1'b0, lvl}));
		ramp_on_n = (lvl_s < raw) && (lvl != ONE_Q15);
		ramp_drive = raw;
		if (raw > lvl_s) ramp_drive = lvl_s;
		else if (raw < -lvl_s) ramp_drive = -lvl_s;
	end

	// output clamp
	logic signed [DRW-1:0] omax, omin, lem_s, fin;
	logic [1:0]            kind;
	always_comb begin
		omax = DRW'($signed(cfg.output_limits[31:16]));
		omin = DRW'($signed(cfg.output_limits[15:0]));
		lem_s = DRW'($signed({1'b0, cfg.low_error_min}));
		fin = drive_q;
		kind = CLAMP_NONE;
		if (drive_q > omax) begin
			fin = omax;
			kind = CLAMP_MAX;
		end else if (drive_q < omin) begin
			fin = omin;
			kind = CLAMP_MIN;
		end else if (!ramp_on_q && drive_q < lem_s && drive_q > -lem_s) begin
			fin = sign_pos_q ? lem_s : -lem_s;
			kind = CLAMP_LEM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			last_err_q <= '0;
			sum_q <= '0;
			level_q <= '0;
			ramp_on_q <= 1'b0;
			sign_pos_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLAMP) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.accept) begin
				case (in_mode)
					MODE_SETPT: begin
						target_q <= tgt_c;
						last_err_q <= sp_err;
						sign_pos_q <= !sp_err[EW-1];
						if (in_restart) begin
							sum_q <= '0;
							level_q <= 17'(cfg.ramp_settings[30:16]);
							ramp_on_q <= (cfg.ramp_settings[30:16] != 15'd0);
						end
					end
					MODE_RESET: begin
						sum_q <= '0;
						level_q <= 17'(cfg.ramp_settings[30:16]);
					end
					default: ;
				endcase
			end
			case (cmd.op)
				OP_SUM: begin
					sum_q <= (ki_q == 16'd0) ? '0 : SUM_WIDTH'(s_c);
					last_err_q <= err_q;
				end
				OP_RAMP: begin
					if (ramp_on_q) begin
						level_q <= lvl;
						ramp_on_q <= ramp_on_n;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) meas_q <= in_measurement;
		case (cmd.op)
			OP_ERR: begin
				err_q <= err_n;
				diff_q <= DFW'(err_n) - DFW'(last_err_q);
				emag_q <= err_n[EW-1] ? EW'(-err_n) : EW'(err_n);
			end
			OP_GAIN: begin
				kp_q <= pick(cfg.p_gains, emag_q);
				ki_q <= pick(cfg.i_gains, emag_q);
				kd_q <= pick(cfg.d_gains, emag_q);
				settled_q <= emag_q <= EW'(cfg.deadband);
			end
			OP_DIV_LO: hi_q <= div_quot;
			OP_MUL_P:  prod_q <= mul_p;
			OP_MUL_I: begin
				acc_q <= AW'(prod_q);
				prod_q <= mul_p;
			end
			OP_MUL_D: begin
				acc_q <= acc_q + AW'(prod_q);
				prod_q <= mul_p;
			end
			OP_ACC: acc_q <= acc_q + AW'(prod_q);
			OP_RAMP: begin
				ramped_q <= ramp_on_q;
				drive_q <= ramp_on_q ? ramp_drive : raw;
			end
			OP_CLAMP: begin
				drive_out_q <= 16'(fin);
				err_out_q <= (DATA_WIDTH + 1)'(err_q);
				settled_out_q <= settled_q;
				ramped_out_q <= ramped_q;
				kind_out_q <= kind;
			end
			default: ;
		endcase
	end

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_drive = drive_out_q;
	assign out_error_now = err_out_q;
	assign out_settled = settled_out_q;
	assign out_ramp_limited = ramped_out_q;
	assign out_clamp_kind = kind_out_q;
endmodule
`default_nettype wire

/* rtl/scheduled_pid_with_ramp.sv */
// ----------------------------------------------------------------------------
// scheduled_pid_with_ramp
// Gain-scheduled PID regulator with start ramp and output clamping.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries words with a mode: sample, new setpoint, or integral and
//   ramp reset. Setpoint and reset words update state in the accept cycle
//   and produce no result. A sample word produces one result on out_ch.
//   A sample passes through the error, gain pick, upper and lower bound
//   division, integral, three multiplies, accumulate, ramp and clamp steps
//   into the result register; the serial divider computes the two integral
//   bounds one quotient bit per cycle. The next word is taken only in the
//   idle state after the clamp, so no word is accepted while a sample is
//   in flight.
//   The result register lets a new word be accepted while a result waits;
//   a stalled receiver holds the next result in the final step.
//   Registers are written over the APB port (64-bit data, 8-byte stride).
//   Reset clears the setpoint, integral, ramp state and the registers
//   (output limits reset to full scale).
// ----------------------------------------------------------------------------
`default_nettype none
module scheduled_pid_with_ramp
	import spwr_pkg::*;
#(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8,
	parameter int SUM_WIDTH      = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	spwr_in_if.sink          in_ch,
	spwr_out_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	spwr_cfg_t    cfg_q;
	spwr_cmd_t    cmd;
	spwr_status_t status;
	spwr_reg_t    idx;
	logic         wr;

	assign pready = 1'b1;
	assign idx = spwr_reg_t'(paddr[5:3]);
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gains <= '0;
			cfg_q.i_gains <= '0;
			cfg_q.d_gains <= '0;
			cfg_q.output_limits <= OUT_LIMITS_RST;
			cfg_q.low_error_min <= '0;
			cfg_q.ramp_settings <= '0;
			cfg_q.input_limits <= '0;
			cfg_q.deadband <= '0;
		end else if (wr) begin
			case (idx)
				REG_P_GAINS:     cfg_q.p_gains <= pwdata[47:0];
				REG_I_GAINS:     cfg_q.i_gains <= pwdata[47:0];
				REG_D_GAINS:     cfg_q.d_gains <= pwdata[47:0];
				REG_OUT_LIMITS:  cfg_q.output_limits <= pwdata[31:0];
				REG_LOW_ERR_MIN: cfg_q.low_error_min <= pwdata[14:0];
				REG_RAMP:        cfg_q.ramp_settings <= pwdata[30:0];
				REG_IN_LIMITS:   cfg_q.input_limits <= pwdata[31:0];
				REG_DEADBAND:    cfg_q.deadband <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_P_GAINS:     prdata = 64'(cfg_q.p_gains);
			REG_I_GAINS:     prdata = 64'(cfg_q.i_gains);
			REG_D_GAINS:     prdata = 64'(cfg_q.d_gains);
			REG_OUT_LIMITS:  prdata = 64'(cfg_q.output_limits);
			REG_LOW_ERR_MIN: prdata = 64'(cfg_q.low_error_min);
			REG_RAMP:        prdata = 64'(cfg_q.ramp_settings);
			REG_IN_LIMITS:   prdata = 64'(cfg_q.input_limits);
			REG_DEADBAND:    prdata = 64'(cfg_q.deadband);
			default:         prdata = '0;
		endcase
	end

	spwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_mode  (in_ch.mode),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	spwr_dp #(
		.DATA_WIDTH     (DATA_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.SUM_WIDTH      (SUM_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (cmd),
		.status           (status),
		.in_mode          (in_ch.mode),
		.in_measurement   (in_ch.measurement),
		.in_target        (in_ch.target),
		.in_restart       (in_ch.restart),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_drive        (out_ch.drive),
		.out_error_now    (out_ch.error_now),
		.out_settled      (out_ch.settled),
		.out_ramp_limited (out_ch.ramp_limited),
		.out_clamp_kind   (out_ch.clamp_kind)
	);
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives sample, setpoint and reset words with random gaps and back-pressure,
// writes the regulator registers over APB between phases, and compares every
// result word against a cycle-free model of the scheduled PID law.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import spwr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] drive;
		logic signed [16:0] error_now;
		logic               settled;
		logic               ramp_limited;
		logic [1:0]         clamp_kind;
	} pid_out_t;

	localparam int LIMIT_CYCLES = 900000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	spwr_in_if #(.DATA_WIDTH(16)) in_ch ();
	spwr_out_if #(.DATA_WIDTH(16)) out_ch ();

	scheduled_pid_with_ramp u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// register image and regulator state
	logic [47:0] p_gains, i_gains, d_gains;
	logic [31:0] output_limits, input_limits;
	logic [14:0] low_error_min;
	logic [30:0] ramp_settings;
	logic [15:0] deadband;
	longint target_held, last_error, error_sum, ramp_level;
	bit ramp_on, sign_positive;

	pid_out_t expected_q[$];
	int errors = 0;
	int cycle = 0;
	bit idle_on = 1'b1;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= LIMIT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint gain_for(logic [47:0] r, longint emag);
		if (r[47:32] != 0 && emag < longint'(r[47:32]))
			return longint'(r[15:0]);
		return longint'(r[31:16]);
	endfunction

	function automatic longint shr_floor(longint v);
		return v >>> 8;
	endfunction

	task automatic pid_apply(logic [1:0] mode, logic signed [15:0] meas,
			logic signed [15:0] tgt_in, logic restart);
		longint tgt, imax, imin, err, diff, emag, kp, ki, kd, omax, omin, lem;
		longint hi, lo, s, drv, lvl, rstart, rstep;
		bit ramped;
		logic [1:0] kind;
		pid_out_t r;
		rstart = longint'(ramp_settings[30:16]);
		rstep = longint'(ramp_settings[15:0]);
		if (mode == MODE_SETPT) begin
			tgt = longint'(tgt_in);
			imax = longint'($signed(input_limits[31:16]));
			imin = longint'($signed(input_limits[15:0]));
			if (imax > imin) begin
				if (tgt > imax) tgt = imax;
				else if (tgt < imin) tgt = imin;
			end
			target_held = tgt;
			last_error = tgt - longint'(meas);
			sign_positive = last_error >= 0;
			if (restart) begin
				error_sum = 0;
				ramp_level = rstart;
				ramp_on = rstart > 0;
			end
		end else if (mode == MODE_RESET) begin
			error_sum = 0;
			ramp_level = rstart;
		end else if (mode == MODE_SAMPLE) begin
			err = target_held - longint'(meas);
			diff = err - last_error;
			emag = abs64(err);
			kp = gain_for(p_gains, emag);
			ki = gain_for(i_gains, emag);
			kd = gain_for(d_gains, emag);
			omax = longint'($signed(output_limits[31:16]));
			omin = longint'($signed(output_limits[15:0]));
			lem = longint'(low_error_min);
			ramped = ramp_on;
			kind = CLAMP_NONE;
			if (ki == 0) error_sum = 0;
			else begin
				hi = (omax * 256) / ki;
				lo = (omin * 256) / ki;
				s = error_sum + err;
				if (s > hi) s = hi;
				if (s < lo) s = lo;
				if (s > 64'sd2147483647) s = 64'sd2147483647;
				if (s < -64'sd2147483648) s = -64'sd2147483648;
				error_sum = s;
			end
			drv = shr_floor(kp * err + ki * error_sum + kd * diff);
			if (ramp_on) begin
				lvl = ramp_level + rstep;
				if (lvl > 32768) lvl = 32768;
				ramp_level = lvl;
				ramp_on = (lvl < drv) && (lvl < 32768);
				if (abs64(drv) > lvl) drv = drv < 0 ? -lvl : lvl;
			end
			if (drv > omax) begin
				drv = omax; kind = CLAMP_MAX;
			end else if (drv < omin) begin
				drv = omin; kind = CLAMP_MIN;
			end else if (!ramp_on && abs64(drv) < lem) begin
				drv = sign_positive ? lem : -lem; kind = CLAMP_LEM;
			end
			last_error = err;
			r.drive = drv[15:0];
			r.error_now = err[16:0];
			r.settled = emag <= longint'(deadband);
			r.ramp_limited = ramped;
			r.clamp_kind = kind;
			expected_q.push_back(r);
		end
	endtask

	task automatic reg_write(spwr_reg_t idx, logic [63:0] value);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 3'b000}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_P_GAINS: p_gains = value[47:0];
			REG_I_GAINS: i_gains = value[47:0];
			REG_D_GAINS: d_gains = value[47:0];
			REG_OUT_LIMITS: output_limits = value[31:0];
			REG_LOW_ERR_MIN: low_error_min = value[14:0];
			REG_RAMP: ramp_settings = value[30:0];
			REG_IN_LIMITS: input_limits = value[31:0];
			default: deadband = value[15:0];
		endcase
	endtask

	// valid stays high across back-to-back words; drop it only for a gap
	task automatic send_word(logic [1:0] mode, logic signed [15:0] meas,
			logic signed [15:0] tgt, logic restart);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.measurement <= meas;
		in_ch.target <= tgt;
		in_ch.restart <= restart;
		do @(posedge clk); while (!in_ch.ready);
		pid_apply(mode, meas, tgt, restart);
	endtask

	// hold until all results are back, then let the sequencer settle
	task automatic wait_quiet();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		pid_out_t got, want;
		if (out_ch.valid && out_ch.ready) begin
			got = '{out_ch.drive, out_ch.error_now, out_ch.settled,
				out_ch.ramp_limited, out_ch.clamp_kind};
			if (expected_q.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.drive !== want.drive) begin
					$error("drive exp %0d got %0d", want.drive, got.drive); errors++;
				end
				if (got.error_now !== want.error_now) begin
					$error("error_now exp %0d got %0d", want.error_now, got.error_now);
					errors++;
				end
				if (got.settled !== want.settled) begin
					$error("settled exp %0b got %0b", want.settled, got.settled); errors++;
				end
				if (got.ramp_limited !== want.ramp_limited) begin
					$error("ramp_limited exp %0b got %0b", want.ramp_limited,
						got.ramp_limited);
					errors++;
				end
				if (got.clamp_kind !== want.clamp_kind) begin
					$error("clamp_kind exp %0d got %0d", want.clamp_kind, got.clamp_kind);
					errors++;
				end
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (idle_on) begin
				gap = $urandom_range(1, 9);
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	function automatic logic [47:0] rand_gains();
		logic [47:0] g;
		g[47:32] = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 2000));
		g[31:16] = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
		g[15:0] = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
		return g;
	endfunction

	task automatic rand_config();
		reg_write(REG_P_GAINS, rand_gains());
		reg_write(REG_I_GAINS, $urandom_range(0, 4) == 0 ? 48'd0 : rand_gains());
		reg_write(REG_D_GAINS, rand_gains());
		reg_write(REG_OUT_LIMITS, $urandom_range(0, 5) == 0 ? 32'($urandom) :
			{16'($urandom_range(1000, 32767)), 16'(-$urandom_range(1000, 32768))});
		reg_write(REG_LOW_ERR_MIN, 15'($urandom_range(0, 3000)));
		reg_write(REG_RAMP, $urandom_range(0, 2) == 0 ? 31'd0 :
			{15'($urandom_range(0, 8000)), 16'($urandom_range(0, 3000))});
		reg_write(REG_IN_LIMITS, 32'($urandom));
		reg_write(REG_DEADBAND, 16'($urandom_range(0, 2000)));
	endtask

	task automatic test_directed();
		reg_write(REG_P_GAINS, {16'd100, 16'd512, 16'd128});
		reg_write(REG_I_GAINS, {16'd0, 16'd64, 16'd0});
		reg_write(REG_D_GAINS, {16'd50, 16'hFFFF, 16'd0});
		reg_write(REG_OUT_LIMITS, {16'sd20000, -16'sd20000});
		reg_write(REG_LOW_ERR_MIN, 15'h7FFF);
		reg_write(REG_RAMP, {15'd100, 16'd500});
		reg_write(REG_IN_LIMITS, {16'sd1000, -16'sd1000});
		reg_write(REG_DEADBAND, 16'd10);
		send_word(MODE_SAMPLE, 16'sh7FFF, 0, 0);
		send_word(MODE_SAMPLE, -16'sh8000, 0, 0);
		send_word(MODE_SETPT, 0, 16'sh7FFF, 1'b1);
		send_word(MODE_SAMPLE, 0, 0, 0);
		send_word(MODE_SAMPLE, 995, 0, 0);
		send_word(MODE_SAMPLE, -16'sh8000, 0, 0);
		send_word(MODE_UNUSED, 16'sh1234, 16'sh4321, 1'b1);
		send_word(MODE_RESET, 0, 0, 0);
		send_word(MODE_SAMPLE, 16'sh7FFF, 0, 0);
		send_word(MODE_SETPT, 16'sh7FFF, -16'sh8000, 0);
		send_word(MODE_SAMPLE, 16'sh7FFF, 0, 0);
		send_word(MODE_SAMPLE, -1000, 0, 0);
		wait_quiet();
		// inverted limits everywhere, ramp at maximum start and step
		reg_write(REG_OUT_LIMITS, {-16'sd100, 16'sd100});
		reg_write(REG_IN_LIMITS, {-16'sd5, 16'sd5});
		reg_write(REG_RAMP, 31'h7FFF_FFFF);
		send_word(MODE_SETPT, 3, 16'sh7FFF, 1'b1);
		send_word(MODE_SAMPLE, 0, 0, 0);
		send_word(MODE_SAMPLE, -16'sh8000, 0, 0);
		send_word(MODE_SAMPLE, 16'sh7FFF, 0, 0);
		wait_quiet();
	endtask

	task automatic test_random(int phases, int words);
		int pick;
		for (int ph = 0; ph < phases; ph++) begin
			rand_config();
			send_word(MODE_SETPT, 16'($urandom), 16'($urandom), 1'b1);
			for (int n = 0; n < words; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 82)
					send_word(MODE_SAMPLE, 16'($urandom_range(0, 3) == 0 ? $urandom :
						target_held + $urandom_range(0, 4000) - 2000), 16'($urandom),
						1'($urandom));
				else if (pick < 92)
					send_word(MODE_SETPT, 16'($urandom), 16'($urandom), 1'($urandom));
				else if (pick < 97)
					send_word(MODE_RESET, 16'($urandom), 16'($urandom), 1'($urandom));
				else
					send_word(MODE_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom));
			end
			wait_quiet();
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_SAMPLE;
		in_ch.measurement = '0;
		in_ch.target = '0;
		in_ch.restart = 1'b0;
		p_gains = '0; i_gains = '0; d_gains = '0;
		output_limits = OUT_LIMITS_RST; input_limits = '0;
		low_error_min = '0; ramp_settings = '0; deadband = '0;
		target_held = 0; last_error = 0; error_sum = 0; ramp_level = 0;
		ramp_on = 0; sign_positive = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(12, 110);
		idle_on = 1'b0;
		test_random(2, 100);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
